/* rtl/core/ipalc_pkg.sv */
`timescale 1ns / 1ps

package ipalc_pkg;

  localparam int ADDR_HALF_W = 64;
  localparam int ADDR_W = 2 * ADDR_HALF_W;
  localparam int SLOT_W = 2;
  localparam int PLEN_W = 8;
  localparam int V6_ENTRIES_DEFAULT = 4;

  // The prefix compare is split into chunks so that the match reduction
  // spreads over two pipeline stages.
  localparam int CHUNK_W = 16;
  localparam int CHUNKS = ADDR_W / CHUNK_W;

  // Configuration register map.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_V4_VALID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_V4_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_V4_NETMASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V6_PREFIX_COUNT = 2'd3;
  localparam int COUNT_W = 3;

  // Request operations.
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Well-known address patterns.
  localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_ffff;
  localparam logic [7:0] OCT_LOOPBACK = 8'd127;
  localparam logic [7:0] OCT_PRIV_A = 8'd10;
  localparam logic [7:0] OCT_PRIV_B = 8'd172;
  localparam logic [3:0] OCT_PRIV_B_HI = 4'h1;
  localparam logic [7:0] OCT_PRIV_C0 = 8'd192;
  localparam logic [7:0] OCT_PRIV_C1 = 8'd168;
  localparam logic [7:0] OCT_LINK0 = 8'd169;
  localparam logic [7:0] OCT_LINK1 = 8'd254;
  localparam logic [9:0] V6_LINK_LOCAL_TAG = 10'h3fa;
  localparam logic [6:0] V6_UNIQUE_LOCAL_TAG = 7'h7e;
  localparam logic [PLEN_W-1:0] PLEN_DEFAULT = 8'd64;
  localparam logic [PLEN_W-1:0] PLEN_MAX = 8'd128;

  typedef struct packed {
    logic en;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] prefix;
    logic [PLEN_W-1:0] bits;
  } prefix_wr_t;

  // Mask with the leading bits of the prefix set. A length of zero stands
  // for 64 bits, and lengths above 128 compare the whole address.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] bits);
    logic [PLEN_W-1:0] n;
    n = bits;
    if (n == '0) begin
      n = PLEN_DEFAULT;
    end
    if (n > PLEN_MAX) begin
      n = PLEN_MAX;
    end
    return ~({ADDR_W{1'b1}} >> n);
  endfunction

endpackage

/* rtl/core/ipalc_req_if.sv */
`timescale 1ns / 1ps

interface ipalc_req_if;
  import ipalc_pkg::*;

  logic valid;
  logic ready;
  logic operation;
  logic [ADDR_HALF_W-1:0] address_high;
  logic [ADDR_HALF_W-1:0] address_low;
  logic [SLOT_W-1:0] entry_index;
  logic [PLEN_W-1:0] prefix_bits;

  modport source (
    output valid, operation, address_high, address_low, entry_index, prefix_bits,
    input ready
  );

  modport sink (
    input valid, operation, address_high, address_low, entry_index, prefix_bits,
    output ready
  );
endinterface

/* rtl/core/ipalc_rsp_if.sv */
`timescale 1ns / 1ps

interface ipalc_rsp_if;
  logic valid;
  logic ready;
  logic is_local;

  modport source (
    output valid, is_local,
    input ready
  );

  modport sink (
    input valid, is_local,
    output ready
  );
endinterface

/* rtl/core/ipalc_prefix_lanes.sv */
`timescale 1ns / 1ps

module ipalc_prefix_lanes #(
  parameter int V6_ENTRIES = ipalc_pkg::V6_ENTRIES_DEFAULT
) (
  input  logic clk,
  input  ipalc_pkg::prefix_wr_t wr,
  input  logic [ipalc_pkg::ADDR_W-1:0] addr,
  output logic [V6_ENTRIES-1:0][ipalc_pkg::CHUNKS-1:0] chunk_ok
);
  import ipalc_pkg::*;

  logic [ADDR_W-1:0] prefix [V6_ENTRIES];
  logic [ADDR_W-1:0] mask [V6_ENTRIES];

  for (genvar k = 0; k < V6_ENTRIES; k++) begin : g_lane
    // Slots at or above the table depth are never selected here.
    always_ff @(posedge clk) begin
      if (wr.en && (32'(wr.slot) == k)) begin
        prefix[k] <= wr.prefix;
        mask[k] <= prefix_mask(wr.bits);
      end
    end

    for (genvar c = 0; c < CHUNKS; c++) begin : g_chunk
      assign chunk_ok[k][c] =
        ~|((addr[c*CHUNK_W +: CHUNK_W] ^ prefix[k][c*CHUNK_W +: CHUNK_W])
           & mask[k][c*CHUNK_W +: CHUNK_W]);
    end
  end

endmodule

/* rtl/core/ip_address_locality_classifier_unit.sv */
`timescale 1ns / 1ps

// Address locality classifier. A request either classifies one 128-bit
// address (IPv4-mapped or IPv6) or loads one slot of the own-prefix table.
// One request is accepted per cycle unless a stalled response holds the
// pipeline. A classify request passes an input register, a stage that
// compares the address against the fixed ranges and every table slot in
// 16-bit chunks, and an output register that folds the chunk results into
// its is_local response. A stalled response holds every stage behind it. A
// table write commits at the edge on which it is accepted, gives no
// response, and is seen by every later classify request. Table slots hold
// no reset value and must be written before the prefix count covers them.
module ip_address_locality_classifier_unit #(
  parameter int V6_ENTRIES = ipalc_pkg::V6_ENTRIES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ipalc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipalc_pkg::CFG_DATA_W-1:0] cfg_data,
  ipalc_req_if.sink addr_in,
  ipalc_rsp_if.source result
);
  import ipalc_pkg::*;

  // Configuration registers.
  logic own_v4_valid;
  logic [31:0] own_v4_address;
  logic [31:0] own_v4_netmask;
  logic [COUNT_W-1:0] v6_prefix_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_v4_valid <= 1'b0;
      own_v4_address <= '0;
      own_v4_netmask <= '0;
      v6_prefix_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_V4_VALID:    own_v4_valid <= cfg_data[0];
        REG_OWN_V4_ADDRESS:  own_v4_address <= cfg_data;
        REG_OWN_V4_NETMASK:  own_v4_netmask <= cfg_data;
        REG_V6_PREFIX_COUNT: v6_prefix_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic s1_valid;
  logic s2_valid;
  logic s1_ready;
  logic s2_ready;
  logic out_ready;
  logic accept;

  assign out_ready = !result.valid || result.ready;
  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign addr_in.ready = s1_ready;
  assign accept = addr_in.valid && s1_ready;

  // Table writes commit on acceptance. A classify request still in stage 1
  // leaves it on that same edge, so it never sees a later write.
  prefix_wr_t wr;
  assign wr.en = accept && (addr_in.operation == OP_WRITE);
  assign wr.slot = addr_in.entry_index;
  assign wr.prefix = {addr_in.address_high, addr_in.address_low};
  assign wr.bits = addr_in.prefix_bits;

  // Stage 1: registered address.
  logic [ADDR_HALF_W-1:0] s1_hi;
  logic [ADDR_HALF_W-1:0] s1_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept && (addr_in.operation == OP_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_hi <= addr_in.address_high;
      s1_lo <= addr_in.address_low;
    end
  end

  logic [V6_ENTRIES-1:0][CHUNKS-1:0] lane_chunk_ok;

  ipalc_prefix_lanes #(
    .V6_ENTRIES(V6_ENTRIES)
  ) u_lanes (
    .clk(clk),
    .wr(wr),
    .addr({s1_hi, s1_lo}),
    .chunk_ok(lane_chunk_ok)
  );

  logic [7:0] oct0;
  logic [7:0] oct1;
  logic v4_mapped;
  logic v4_local;
  logic v6_fixed_local;

  assign oct0 = s1_lo[31:24];
  assign oct1 = s1_lo[23:16];
  assign v4_mapped = (s1_hi == '0) && (s1_lo[63:32] == V4_MAPPED_TAG);

  always_comb begin
    v4_local = (oct0 == OCT_LOOPBACK) || (oct0 == OCT_PRIV_A)
      || ((oct0 == OCT_PRIV_B) && (oct1[7:4] == OCT_PRIV_B_HI))
      || ((oct0 == OCT_PRIV_C0) && (oct1 == OCT_PRIV_C1))
      || ((oct0 == OCT_LINK0) && (oct1 == OCT_LINK1))
      || (own_v4_valid
          && ((s1_lo[31:0] & own_v4_netmask) == (own_v4_address & own_v4_netmask)));
    v6_fixed_local = ((s1_hi == '0) && (s1_lo == ADDR_HALF_W'(1)))
      || (s1_hi[63:54] == V6_LINK_LOCAL_TAG)
      || (s1_hi[63:57] == V6_UNIQUE_LOCAL_TAG);
  end

  // Stage 2: partial compare results.
  logic s2_v4_mapped;
  logic s2_v4_local;
  logic s2_v6_fixed;
  logic [V6_ENTRIES-1:0][CHUNKS-1:0] s2_lane_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_v4_mapped <= v4_mapped;
      s2_v4_local <= v4_local;
      s2_v6_fixed <= v6_fixed_local;
      s2_lane_ok <= lane_chunk_ok;
    end
  end

  logic [V6_ENTRIES-1:0] lane_hit;
  logic local_next;

  for (genvar k = 0; k < V6_ENTRIES; k++) begin : g_hit
    assign lane_hit[k] = (&s2_lane_ok[k]) && (k < 32'(v6_prefix_count));
  end

  assign local_next = s2_v4_mapped ? s2_v4_local : (s2_v6_fixed || (|lane_hit));

  // Stage 3: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_ready) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      result.is_local <= local_next;
    end
  end

`ifndef SYNTHESIS
  a_write_no_item: assert property (@(posedge clk) disable iff (rst)
    (accept && (addr_in.operation == OP_WRITE)) |=> !s1_valid)
    else $error("table write entered the classify pipeline");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_lane_ok) && $stable(s2_v6_fixed)))
    else $error("stage 2 changed while stalled");

  a_loopback_v6: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_ready && (s1_hi == '0) && (s1_lo == ADDR_HALF_W'(1)))
      |=> (s2_v6_fixed && !s2_v4_mapped))
    else $error("::1 not flagged as local");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!result.valid && !s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
